>>> design/lpkvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkvt_pkg: shared types and constants
// Table geometry, result codes and the control/status bundles between the
// probe controller and the table datapath.
// ----------------------------------------------------------------------------
package lpkvt_pkg;

   localparam int CAPACITY   = 64;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = SLOT_W + 1;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 64;
   localparam int LOAD_LIMIT = (CAPACITY * 3) / 4;

   typedef enum logic [1:0] {
      ST_HIT  = 2'd0,
      ST_NEW  = 2'd1,
      ST_FULL = 2'd2,
      ST_ZERO = 2'd3
   } status_type;

   typedef struct packed {
      logic       load_req;   // capture request, start probe at home slot
      logic       advance;    // step to next slot
      logic       wr_hit;     // commit a put to a matching slot
      logic       wr_new;     // claim the empty slot
      logic       set_res;    // capture result fields
      status_type res_code;
      logic       load_rsp;   // move result into output register
   } dp_cmd_type;

   typedef struct packed {
      logic key_zero;   // key on the request port is zero
      logic match;      // probed slot holds the key
      logic empty;      // probed slot is empty
      logic at_limit;   // used count at the load limit
      logic last_probe; // every slot has been visited
      logic rsp_free;   // output register can take a result
   } dp_stat_type;

endpackage

>>> design/lpkvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkvt_ctrl: probe controller
// Sequences accept, slot read, compare and result hand-off for one request.
// ----------------------------------------------------------------------------
module lpkvt_ctrl
   import lpkvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      cmd.res_code = ST_HIT;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (stat.key_zero) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_ZERO;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            priority if (stat.match) begin
               cmd.wr_hit   = 1'b1;
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_HIT;
               state_in     = S_DONE;
            end else if (stat.empty) begin
               cmd.set_res = 1'b1;
               if (stat.at_limit) begin
                  cmd.res_code = ST_FULL;
               end else begin
                  cmd.wr_new   = 1'b1;
                  cmd.res_code = ST_NEW;
               end
               state_in = S_DONE;
            end else if (stat.last_probe) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_FULL;
               state_in     = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/lpkvt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpkvt_dp: table datapath
// Key and value memories, per-slot valid and held bits, probe pointer,
// used count, result capture and the output register.
// ----------------------------------------------------------------------------
module lpkvt_dp
   import lpkvt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   input  logic               req_func,
   input  logic [KEY_W-1:0]   req_key_hash,
   input  logic [VAL_W-1:0]   req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VAL_W-1:0]   rsp_value_out,
   output logic               rsp_value_present,
   output logic [1:0]         rsp_status
);

   logic [KEY_W-1:0]    key_mem [CAPACITY];
   logic [VAL_W-1:0]    val_mem [CAPACITY];
   logic [CAPACITY-1:0] key_valid_ff;
   logic [CAPACITY-1:0] held_ff;

   logic                is_put_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   probe_cnt_ff;
   logic [CNT_W-1:0]    used_cnt_ff;

   logic [KEY_W-1:0]    key_rd_ff;
   logic [VAL_W-1:0]    val_rd_ff;
   logic [KEY_W-1:0]    key_rd;
   logic                held_rd;

   logic [VAL_W-1:0]    res_val_ff;
   logic                res_present_ff;
   status_type          res_code_ff;
   logic [VAL_W-1:0]    res_val_in;
   logic                res_present_in;

   logic                rsp_valid_ff;
   logic [VAL_W-1:0]    rsp_val_ff;
   logic                rsp_present_ff;
   status_type          rsp_code_ff;

   // a slot never claimed reads as empty
   assign key_rd  = key_valid_ff[slot_ff] ? key_rd_ff : '0;
   assign held_rd = held_ff[slot_ff];

   assign stat.key_zero   = (req_key_hash == '0);
   assign stat.match      = (key_rd == key_ff);
   assign stat.empty      = (key_rd == '0);
   assign stat.at_limit   = (used_cnt_ff >= CNT_W'(LOAD_LIMIT));
   assign stat.last_probe = (probe_cnt_ff == SLOT_W'(CAPACITY - 1));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[slot_ff];
      if (cmd.wr_new) begin
         key_mem[slot_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_rd_ff <= val_mem[slot_ff];
      if ((cmd.wr_hit || cmd.wr_new) && is_put_ff) begin
         val_mem[slot_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
         held_ff      <= '0;
         used_cnt_ff  <= '0;
      end else begin
         if (cmd.wr_new) begin
            key_valid_ff[slot_ff] <= 1'b1;
            held_ff[slot_ff]      <= is_put_ff;
            used_cnt_ff           <= used_cnt_ff + 1'b1;
         end else if (cmd.wr_hit && is_put_ff) begin
            held_ff[slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_put_ff    <= req_func;
         key_ff       <= req_key_hash;
         val_ff       <= req_value_in;
         slot_ff      <= req_key_hash[SLOT_W-1:0];
         probe_cnt_ff <= '0;
      end else if (cmd.advance) begin
         slot_ff      <= slot_ff + 1'b1;
         probe_cnt_ff <= probe_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      res_val_in     = '0;
      res_present_in = 1'b0;
      unique case (cmd.res_code)
         ST_HIT: begin
            res_present_in = is_put_ff || held_rd;
            if (!is_put_ff && held_rd) begin
               res_val_in = val_rd_ff;
            end
         end
         ST_NEW:  res_present_in = is_put_ff;
         ST_FULL: res_present_in = 1'b0;
         ST_ZERO: res_present_in = 1'b0;
         default: res_present_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         res_val_ff     <= res_val_in;
         res_present_ff <= res_present_in;
         res_code_ff    <= cmd.res_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_val_ff     <= res_val_ff;
         rsp_present_ff <= res_present_ff;
         rsp_code_ff    <= res_code_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value_out     = rsp_val_ff;
   assign rsp_value_present = rsp_present_ff;
   assign rsp_status        = rsp_code_ff;

endmodule

>>> design/linear_probe_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_value_table: open-addressing key/value table
// Get/put by 32-bit key hash with linear probing over a 64-slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries func (0 get, 1 put),
//   key_hash and value_in. Response channel (rsp_valid/rsp_ready) returns
//   value_out, value_present and status, one response per request.
//   A request is taken only while the block is idle. Each probed slot goes
//   through a read state (registered key/value memory read), then a check
//   state (compare/commit), for up to CAPACITY probes. The next request is
//   taken only after the result of the previous one has moved into the
//   output register, which raises rsp_valid. A zero key is answered
//   through the result capture alone, without touching the table.
//   The response sits in an output register; while rsp_ready is low the
//   block finishes the next request and then holds it until the register
//   drains. Synchronous reset empties the table at once (per-slot valid
//   bits) and clears the used count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table
   import lpkvt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [KEY_W-1:0] req_key_hash,
   input  logic [VAL_W-1:0] req_value_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [VAL_W-1:0] rsp_value_out,
   output logic             rsp_value_present,
   output logic [1:0]       rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   lpkvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lpkvt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_key_hash      (req_key_hash),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_out     (rsp_value_out),
      .rsp_value_present (rsp_value_present),
      .rsp_status        (rsp_status)
   );

endmodule

>>> test/linear_probe_key_value_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_key_value_table_tb: get/put checks on the linear-probe table
// Sends get and put requests and keeps its own copy of the slot keys, values,
// held bits and claimed-slot count. From that copy it works out the response
// to each accepted request. Each response is compared field by field with
// the oldest outstanding prediction. Covers zero keys, collisions with
// wraparound, clustered random traffic and refusals at the load limit.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table_tb;
   import lpkvt_pkg::*;

   localparam int   CYCLE_LIMIT  = 400000;
   localparam int   DRAIN_CYCLES = 2 * CAPACITY + 8;
   localparam int   RANDOM_ITEMS = 600;
   localparam int   POOL_SIZE    = 96;
   localparam logic FUNC_GET     = 1'b0;
   localparam logic FUNC_PUT     = 1'b1;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             present;
      status_type       status;
   } access_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_func = FUNC_GET;
   logic [KEY_W-1:0] req_key_hash = '0;
   logic [VAL_W-1:0] req_value_in = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VAL_W-1:0] rsp_value_out;
   logic             rsp_value_present;
   logic [1:0]       rsp_status;

   logic        req_gaps_on = 1'b1;
   logic        rsp_stalls_on = 1'b1;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // table copy used to predict responses
   logic [KEY_W-1:0] slot_key [CAPACITY];
   logic [VAL_W-1:0] slot_value [CAPACITY];
   logic             slot_held [CAPACITY];
   int unsigned      keys_claimed;

   access_result_type pending_results [$];
   logic [KEY_W-1:0]  key_pool [POOL_SIZE];

   linear_probe_key_value_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_key_hash      (req_key_hash),
      .req_value_in      (req_value_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value_out     (rsp_value_out),
      .rsp_value_present (rsp_value_present),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_stalls_on || ($urandom_range(99) >= 33);
   end

   // Probe from the home slot, claim the first empty slot for a new key.
   function automatic access_result_type apply_table_access(input logic is_put,
         input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] value);
      access_result_type res;
      logic [SLOT_W-1:0] slot;
      logic              found;
      logic              empty;
      res.value   = '0;
      res.present = 1'b0;
      res.status  = ST_HIT;
      found       = 1'b0;
      empty       = 1'b0;
      if (key == '0) begin
         res.status = ST_ZERO;
         return res;
      end
      slot = key[SLOT_W-1:0];
      for (int n = 0; n < CAPACITY; n++) begin
         if (slot_key[slot] == key) begin
            found = 1'b1;
            break;
         end
         if (slot_key[slot] == '0) begin
            empty = 1'b1;
            break;
         end
         slot = slot + 1'b1;
      end
      if (found) begin
         if (is_put) begin
            slot_value[slot] = value;
            slot_held[slot]  = 1'b1;
            res.present      = 1'b1;
         end else if (slot_held[slot]) begin
            res.value   = slot_value[slot];
            res.present = 1'b1;
         end
         return res;
      end
      if (!empty || keys_claimed >= LOAD_LIMIT) begin
         res.status = ST_FULL;
         return res;
      end
      slot_key[slot]  = key;
      slot_held[slot] = is_put;
      if (is_put)
         slot_value[slot] = value;
      keys_claimed++;
      res.present = is_put;
      res.status  = ST_NEW;
      return res;
   endfunction

   task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      while (req_gaps_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_key_hash <= key;
      req_value_in <= value;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(apply_table_access(func, key, value));
   endtask

   always @(posedge clock) begin : check_response
      access_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response: expected none, %s %h %s %b %s %0d",
                     $time, "actual value", rsp_value_out, "present",
                     rsp_value_present, "status", rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_value_out !== want.value) begin
               $display("%0t: value_out mismatch: expected %h actual %h",
                        $time, want.value, rsp_value_out);
               error_count++;
            end
            if (rsp_value_present !== want.present) begin
               $display("%0t: value_present mismatch: expected %b actual %b",
                        $time, want.present, rsp_value_present);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   task automatic test_zero_key();
      send_request(FUNC_GET, '0, '0);
      send_request(FUNC_PUT, '0, '1);
   endtask

   task automatic test_get_put();
      // get on an unknown key claims the slot without a value
      send_request(FUNC_GET, 32'hFFFF_FFFF, '1);
      send_request(FUNC_GET, 32'hFFFF_FFFF, '0);
      send_request(FUNC_PUT, 32'hFFFF_FFFF, '1);
      send_request(FUNC_GET, 32'hFFFF_FFFF, '0);
      send_request(FUNC_PUT, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
      send_request(FUNC_GET, 32'hAAAA_AAAA, '0);
      send_request(FUNC_PUT, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
      send_request(FUNC_GET, 32'hAAAA_AAAA, '1);
   endtask

   task automatic test_collision_wrap();
      // home slot of 0x7F is the last one, already taken: wrap to slot 0
      send_request(FUNC_PUT, 32'h0000_007F, 64'h8000_0000_0000_0001);
      send_request(FUNC_GET, 32'h0000_007F, '0);
      send_request(FUNC_PUT, 32'h0000_0040, 64'h0123_4567_89AB_CDEF);
      send_request(FUNC_GET, 32'h0000_0001, '0);
      send_request(FUNC_PUT, 32'h0000_0001, 64'hFEDC_BA98_7654_3210);
      send_request(FUNC_GET, 32'h0000_0001, '0);
      send_request(FUNC_PUT, 32'h8000_0000, '0);
      send_request(FUNC_GET, 32'h8000_0000, '1);
   endtask

   task automatic test_random_traffic();
      int unsigned      pick;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      // crowd a few home slots so probe chains grow long and wrap
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
         case (i % 3)
            0: key_pool[i][SLOT_W-1:0] = SLOT_W'($urandom_range(7));
            1: key_pool[i][SLOT_W-1:0] = SLOT_W'($urandom_range(CAPACITY-1, CAPACITY-4));
            default: ;
         endcase
         if (key_pool[i] == '0)
            key_pool[i] = 32'h1;
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         req_gaps_on   = !(i >= 200 && i < 350);
         rsp_stalls_on = req_gaps_on;
         pick  = $urandom_range(99);
         value = {$urandom, $urandom};
         if (pick < 8)
            key = '0;
         else if (pick < 22)
            key = $urandom;
         else
            key = key_pool[$urandom_range(POOL_SIZE-1)];
         send_request(1'($urandom_range(1)), key, value);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_load_limit();
      while (keys_claimed < LOAD_LIMIT)
         send_request(FUNC_PUT, $urandom, {$urandom, $urandom});
      // new keys are refused, present keys still answer
      send_request(FUNC_PUT, 32'h1357_9BDF, '1);
      send_request(FUNC_GET, 32'h2468_ACE0, '0);
      send_request(FUNC_PUT, 32'hFFFF_FFFE, '1);
      send_request(FUNC_GET, 32'hFFFF_FFFF, '0);
      send_request(FUNC_PUT, 32'h0000_007F, 64'h0F0F_F0F0_0F0F_F0F0);
      send_request(FUNC_GET, 32'h0000_007F, '0);
      send_request(FUNC_GET, 32'h0000_0000, '0);
   endtask

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_held[i]  = 1'b0;
      end
      keys_claimed = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_zero_key();
      test_get_put();
      test_collision_wrap();
      test_random_traffic();
      test_load_limit();
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
